// ===== hw/rtl/mbps_pkg.sv =====
// Shared types and constants of the masked byte pattern scanner.
package mbps_pkg;

	localparam int PAT_BYTES = 32;
	localparam int SIG_SLOTS = 64;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_W = 6;
	localparam int OUT_OFF_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LO     = 3'd0,
		REG_PAT_MID_LO = 3'd1,
		REG_PAT_MID_HI = 3'd2,
		REG_PAT_HI     = 3'd3,
		REG_WILD_MASK  = 3'd4,
		REG_PAT_LEN    = 3'd5
	} reg_idx_t;

	// Signature laid out per window slot: slot j is compared against sig[j].
	typedef struct packed {
		logic [SIG_SLOTS-1:0][7:0] sig;
		logic [SIG_SLOTS-1:0]      wild;
		logic [SIG_SLOTS-1:0]      act;
		logic [LEN_W-1:0]          len;
	} cfg_t;

endpackage

// ===== hw/rtl/mbps_if.sv =====
// Handshake channels of the masked byte pattern scanner.
interface mbps_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface mbps_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] match_offset;
	modport source(output valid, found, match_offset, input ready);
	modport sink(input valid, found, match_offset, output ready);
endinterface

interface mbps_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mbps_cfg.sv =====
// Configuration registers and per-slot alignment of the signature.
module mbps_cfg #(
	parameter int MAX_PATTERN_LEN = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]  wr_idx,
	input  logic [mbps_pkg::CFG_DATA_W-1:0] wr_data,
	output mbps_pkg::cfg_t                  slot_cfg
);

	localparam logic [mbps_pkg::LEN_W-1:0] LEN_CAP =
		(MAX_PATTERN_LEN > 63) ? 6'd63 : 6'(MAX_PATTERN_LEN);

	logic [mbps_pkg::PAT_BYTES-1:0][7:0] sig_q;
	logic [mbps_pkg::PAT_BYTES-1:0]      wild_q;
	logic [mbps_pkg::LEN_W-1:0]          len_q;

	logic [mbps_pkg::LEN_W-1:0]          eff_len;
	logic [mbps_pkg::LEN_W:0]            sh;
	logic [mbps_pkg::SIG_SLOTS*8-1:0]    rev_sig;
	logic [mbps_pkg::SIG_SLOTS-1:0]      rev_wild;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q  <= '0;
			wild_q <= '0;
			len_q  <= 6'd1;
		end else if (wr_en) begin
			case (wr_idx)
				mbps_pkg::REG_PAT_LO:     sig_q[7:0]   <= wr_data;
				mbps_pkg::REG_PAT_MID_LO: sig_q[15:8]  <= wr_data;
				mbps_pkg::REG_PAT_MID_HI: sig_q[23:16] <= wr_data;
				mbps_pkg::REG_PAT_HI:     sig_q[31:24] <= wr_data;
				mbps_pkg::REG_WILD_MASK:  wild_q <= wr_data[31:0];
				mbps_pkg::REG_PAT_LEN:    len_q  <= wr_data[5:0];
				default: ;
			endcase
		end
	end

	assign eff_len = (len_q > LEN_CAP) ? LEN_CAP : len_q;
	assign sh      = 7'(mbps_pkg::SIG_SLOTS) - {1'b0, eff_len};

	// Reverse signature into the top slots, then shift down by 64 - len so
	// that slot j holds signature byte len-1-j.
	always_comb begin
		rev_sig  = '0;
		rev_wild = '0;
		for (int m = 0; m < mbps_pkg::PAT_BYTES; m++) begin
			rev_sig[(mbps_pkg::SIG_SLOTS-1-m)*8 +: 8] = sig_q[m];
			rev_wild[mbps_pkg::SIG_SLOTS-1-m]         = wild_q[m];
		end
	end

	assign slot_cfg.sig  = rev_sig >> {sh, 3'b000};
	assign slot_cfg.wild = rev_wild >> sh;
	assign slot_cfg.act  = {mbps_pkg::SIG_SLOTS{1'b1}} >> sh;
	assign slot_cfg.len  = eff_len;

endmodule

// ===== hw/rtl/mbps_cell.sv =====
// One window slot: holds a byte, passes it on and compares the incoming byte.
module mbps_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift_en,
	input  logic       clear,
	input  logic [7:0] byte_in,
	input  logic [7:0] sig_byte,
	input  logic       wild,
	input  logic       active,
	output logic [7:0] byte_q,
	output logic       hit
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift_en) begin
			byte_q <= clear ? 8'd0 : byte_in;
		end
	end

	// Compare the byte this slot takes on in this request.
	assign hit = !active || wild || (byte_in == sig_byte);

endmodule

// ===== hw/rtl/masked_byte_pattern_scanner.sv =====
// Top level of the masked byte pattern scanner.
// A byte that completes a match, or a last byte with no match, has its result registered as it is accepted.
// Throughput: one byte per cycle while the input is not stalled; the window is a chain of cells that all
// compare in parallel within the cycle the byte enters.
// The output register frees as it is taken, so input stalls only on a held result.
// Reset (arst_n low) clears window, position, found flag and result, and sets a zero signature of length one.
module masked_byte_pattern_scanner #(
	parameter int MAX_PATTERN_LEN = 32,
	parameter int OFFSET_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	mbps_cfg_if.sink   cfg,
	mbps_in_if.sink    data_in,
	mbps_out_if.source result
);

	mbps_pkg::cfg_t             cfg_w;
	logic [7:0]                 win [MAX_PATTERN_LEN];
	logic [MAX_PATTERN_LEN-1:0] hit;

	logic [OFFSET_BITS-1:0]     pos_q;
	logic                       found_q;
	logic                       out_vld_q;
	logic                       out_found_q;
	logic [31:0]                out_off_q;

	logic                       acc_in;
	logic                       check;
	logic [mbps_pkg::LEN_W-1:0] len_m1;
	logic                       pos_ok;
	logic                       matched;
	logic                       emit_miss;
	logic [OFFSET_BITS-1:0]     off_full;

	assign cfg.ready = 1'b1;

	mbps_cfg #(
		.MAX_PATTERN_LEN(MAX_PATTERN_LEN)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg.valid),
		.wr_idx  (cfg.index),
		.wr_data (cfg.data),
		.slot_cfg(cfg_w)
	);

	assign acc_in        = data_in.valid && data_in.ready;
	assign data_in.ready = !out_vld_q || result.ready;

	for (genvar j = 0; j < MAX_PATTERN_LEN; j++) begin : g_cell
		logic [7:0] byte_in;
		logic [7:0] sig_byte;
		logic       wild;
		logic       active;

		if (j == 0) begin : g_head
			assign byte_in = data_in.data_byte;
		end else begin : g_link
			assign byte_in = win[j-1];
		end

		if (j < mbps_pkg::SIG_SLOTS) begin : g_sig
			assign sig_byte = cfg_w.sig[j];
			assign wild     = cfg_w.wild[j];
			assign active   = cfg_w.act[j];
		end else begin : g_nosig
			assign sig_byte = 8'd0;
			assign wild     = 1'b0;
			assign active   = 1'b0;
		end

		mbps_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift_en(acc_in),
			.clear   (data_in.last_byte),
			.byte_in (byte_in),
			.sig_byte(sig_byte),
			.wild    (wild),
			.active  (active),
			.byte_q  (win[j]),
			.hit     (hit[j])
		);
	end

	// No check once found or while the position is saturated.
	assign check     = !found_q && !(&pos_q);
	assign len_m1    = cfg_w.len - 6'd1;
	assign pos_ok    = pos_q >= OFFSET_BITS'(len_m1);
	assign matched   = check && (cfg_w.len != '0) && pos_ok && (&hit);
	assign emit_miss = data_in.last_byte && !found_q && !matched;
	assign off_full  = pos_q - OFFSET_BITS'(len_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			found_q <= 1'b0;
		end else if (acc_in) begin
			if (data_in.last_byte) begin
				pos_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (check) begin
					pos_q <= pos_q + 1'b1;
				end
				if (matched) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			out_found_q <= 1'b0;
			out_off_q   <= '0;
		end else if (acc_in && (matched || emit_miss)) begin
			out_vld_q   <= 1'b1;
			out_found_q <= matched;
			out_off_q   <= matched ? 32'(off_full) : 32'd0;
		end else if (result.ready) begin
			out_vld_q   <= 1'b0;
		end
	end

	assign result.valid        = out_vld_q;
	assign result.found        = out_found_q;
	assign result.match_offset = out_off_q;

	a_region_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in && data_in.last_byte |=> !found_q && (pos_q == '0))
		else $error("region state not cleared after last byte");

	a_miss_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_found_q |-> out_off_q == 32'd0)
		else $error("not-found result carries nonzero offset");

	a_found_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(found_q) |-> out_vld_q && out_found_q)
		else $error("found flag set without a found result");

	a_stall_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!data_in.ready |-> out_vld_q)
		else $error("input stalled with no result pending");

endmodule
